[rtl/mstd_pkg.sv]
`timescale 1ns / 1ps
package mstd_pkg;

  localparam int SMP_W   = 16;
  localparam int OUT_W   = 20;
  localparam int SEEN_W  = 6;
  localparam int SUM_W   = 22;
  localparam int SQ_W    = 36;
  localparam int NQ_W    = SQ_W + SEEN_W;
  localparam int SS_W    = 2 * SUM_W;
  localparam int RAD_W   = SS_W + 8;
  localparam int ROOT_W  = RAD_W / 2;
  localparam int REM_W   = ROOT_W + 3;
  localparam int DIV_W   = SUM_W + 4;
  localparam int STEPS   = ROOT_W;
  localparam int STEP_W  = $clog2(STEPS);
  localparam int CNT_RST = 24;
  localparam int MAX_SAMPLES_DEF = 32;
  localparam int ADDR_W  = 3;

  localparam logic [ADDR_W-1:0] ADDR_SAMPLE_COUNT = '0;

  typedef struct packed {
    logic signed [SMP_W-1:0] sample_a;
    logic signed [SMP_W-1:0] sample_b;
  } sample_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] mean_a;
    logic signed [OUT_W-1:0] mean_b;
    logic [OUT_W-1:0]        deviation_a;
    logic [OUT_W-1:0]        deviation_b;
  } result_t;

  typedef struct packed {
    logic load;
    logic acc;
    logic ch;
    logic prod;
    logic diff;
    logic sqrt_step;
    logic div_init;
    logic div_sel;
    logic div_step;
    logic dev_wr;
    logic mean_wr;
  } mstd_cmd_t;

  typedef struct packed {
    logic close;
  } mstd_status_t;

endpackage

[rtl/mstd_ctrl.sv]
`timescale 1ns / 1ps
module mstd_ctrl import mstd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  mstd_status_t status,
  output mstd_cmd_t    cmd,
  output logic         busy,
  output logic         result_valid
);

  typedef enum logic [3:0] {
    S_IDLE, S_ACC, S_MUL, S_SUB, S_SQRT, S_DEVI, S_DEVD, S_MEANI, S_MEAND, S_WRM, S_OUT
  } state_t;

  state_t              state;
  logic                ch;
  logic [STEP_W-1:0]   cnt;

  localparam logic [STEP_W-1:0] LastStep = STEP_W'(STEPS - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ch    <= 1'b0;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (start) state <= S_ACC;
        S_ACC: begin
          ch    <= 1'b0;
          state <= status.close ? S_MUL : S_IDLE;
        end
        S_MUL: state <= S_SUB;
        S_SUB: begin
          cnt   <= '0;
          state <= S_SQRT;
        end
        S_SQRT: begin
          cnt <= cnt + 1'b1;
          if (cnt == LastStep) state <= S_DEVI;
        end
        S_DEVI: begin
          cnt   <= '0;
          state <= S_DEVD;
        end
        S_DEVD: begin
          cnt <= cnt + 1'b1;
          if (cnt == LastStep) state <= S_MEANI;
        end
        S_MEANI: begin
          cnt   <= '0;
          state <= S_MEAND;
        end
        S_MEAND: begin
          cnt <= cnt + 1'b1;
          if (cnt == LastStep) state <= S_WRM;
        end
        S_WRM: begin
          if (!ch) begin
            ch    <= 1'b1;
            state <= S_MUL;
          end else begin
            state <= S_OUT;
          end
        end
        S_OUT: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.ch        = ch;
    cmd.load      = (state == S_IDLE) && start;
    cmd.acc       = (state == S_ACC);
    cmd.prod      = (state == S_MUL);
    cmd.diff      = (state == S_SUB);
    cmd.sqrt_step = (state == S_SQRT);
    cmd.div_init  = (state == S_DEVI) || (state == S_MEANI);
    cmd.div_sel   = (state == S_MEANI);
    cmd.div_step  = (state == S_DEVD) || (state == S_MEAND);
    cmd.dev_wr    = (state == S_MEANI);
    cmd.mean_wr   = (state == S_WRM);
  end

  assign busy         = (state != S_IDLE);
  assign result_valid = (state == S_OUT);

endmodule

[rtl/mstd_datapath.sv]
`timescale 1ns / 1ps
module mstd_datapath import mstd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  mstd_cmd_t         cmd,
  output mstd_status_t      status,
  input  sample_t           sample,
  input  logic [SEEN_W-1:0] n_eff,
  output result_t           result
);

  sample_t                   smp;
  logic [SEEN_W-1:0]         seen;
  logic signed [SUM_W-1:0]   total_a, total_b;
  logic [SQ_W-1:0]           sqt_a, sqt_b;
  logic [SEEN_W-1:0]         set_n;
  logic signed [SUM_W-1:0]   set_sum_a, set_sum_b;
  logic [SQ_W-1:0]           set_sq_a, set_sq_b;
  logic [NQ_W-1:0]           nq;
  logic [SS_W-1:0]           ss;
  logic [RAD_W-1:0]          rad;
  logic [ROOT_W-1:0]         root;
  logic [REM_W-1:0]          rem;
  logic [DIV_W-1:0]          dq;
  logic [SEEN_W:0]           drem;
  result_t                   res;

  logic signed [2*SMP_W-1:0] sq_a, sq_b;
  logic signed [SUM_W-1:0]   sum_a_next, sum_b_next;
  logic [SQ_W-1:0]           sqt_a_next, sqt_b_next;
  logic [SEEN_W:0]           seen_inc;
  logic signed [SUM_W-1:0]   sum_sel;
  logic [SUM_W-1:0]          sum_mag;
  logic [SQ_W-1:0]           sq_sel;
  logic [NQ_W-1:0]           nq_c;
  logic [SS_W-1:0]           ss_c, diff_c;
  logic [REM_W-1:0]          rem_t, trial;
  logic [SEEN_W:0]           div_t;
  logic                      div_ge;
  logic [DIV_W-1:0]          dividend;
  logic [DIV_W-1:0]          mean_v;

  assign sq_a       = $signed(smp.sample_a) * $signed(smp.sample_a);
  assign sq_b       = $signed(smp.sample_b) * $signed(smp.sample_b);
  assign sum_a_next = total_a + SUM_W'(smp.sample_a);
  assign sum_b_next = total_b + SUM_W'(smp.sample_b);
  assign sqt_a_next = sqt_a + SQ_W'(unsigned'(sq_a));
  assign sqt_b_next = sqt_b + SQ_W'(unsigned'(sq_b));
  assign seen_inc   = {1'b0, seen} + 1'b1;
  assign status.close = (seen_inc >= {1'b0, n_eff});

  assign sum_sel = cmd.ch ? set_sum_b : set_sum_a;
  assign sq_sel  = cmd.ch ? set_sq_b : set_sq_a;
  assign sum_mag = sum_sel[SUM_W-1] ? unsigned'(-sum_sel) : unsigned'(sum_sel);
  assign nq_c    = set_n * sq_sel;
  assign ss_c    = sum_mag * sum_mag;
  assign diff_c  = SS_W'(nq) - ss;

  // restoring square root, two radicand bits per step
  assign rem_t = {rem[REM_W-3:0], rad[RAD_W-1 -: 2]};
  assign trial = {1'b0, root, 2'b01};

  assign dividend = cmd.div_sel ? {sum_mag, 4'b0000} : DIV_W'(root);
  assign div_t    = {drem[SEEN_W-1:0], dq[DIV_W-1]};
  assign div_ge   = (div_t >= {1'b0, set_n});

  // floor for negative sums: -(q+1) when a remainder is left
  always_comb begin
    if (sum_sel[SUM_W-1]) begin
      mean_v = (drem != '0) ? ~dq : -dq;
    end else begin
      mean_v = dq;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen    <= '0;
      total_a <= '0;
      total_b <= '0;
      sqt_a   <= '0;
      sqt_b   <= '0;
    end else if (cmd.acc) begin
      if (status.close) begin
        seen    <= '0;
        total_a <= '0;
        total_b <= '0;
        sqt_a   <= '0;
        sqt_b   <= '0;
      end else begin
        seen    <= seen_inc[SEEN_W-1:0];
        total_a <= sum_a_next;
        total_b <= sum_b_next;
        sqt_a   <= sqt_a_next;
        sqt_b   <= sqt_b_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) smp <= sample;
    if (cmd.acc && status.close) begin
      set_n     <= seen_inc[SEEN_W-1:0];
      set_sum_a <= sum_a_next;
      set_sum_b <= sum_b_next;
      set_sq_a  <= sqt_a_next;
      set_sq_b  <= sqt_b_next;
    end
    if (cmd.prod) begin
      nq <= nq_c;
      ss <= ss_c;
    end
    if (cmd.diff) begin
      rad  <= {diff_c, 8'b0};
      root <= '0;
      rem  <= '0;
    end else if (cmd.sqrt_step) begin
      rad <= {rad[RAD_W-3:0], 2'b00};
      if (rem_t >= trial) begin
        rem  <= rem_t - trial;
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_t;
        root <= {root[ROOT_W-2:0], 1'b0};
      end
    end
    if (cmd.div_init) begin
      dq   <= dividend;
      drem <= '0;
    end else if (cmd.div_step) begin
      dq   <= {dq[DIV_W-2:0], div_ge};
      drem <= div_ge ? div_t - {1'b0, set_n} : div_t;
    end
    if (cmd.dev_wr) begin
      if (cmd.ch) res.deviation_b <= dq[OUT_W-1:0];
      else        res.deviation_a <= dq[OUT_W-1:0];
    end
    if (cmd.mean_wr) begin
      if (cmd.ch) res.mean_b <= mean_v[OUT_W-1:0];
      else        res.mean_a <= mean_v[OUT_W-1:0];
    end
  end

  assign result = res;

endmodule

[rtl/mean_and_std_deviation.sv]
`timescale 1ns / 1ps
// two-channel population mean and standard deviation
//
// items enter on start/sample, taken when start is high and busy is low.
// each item holds two 16-bit signed samples with four fraction bits.
// an item that does not close a set is captured, then accumulated.
// the item that closes a set starts the statistics pass, after which
// result_valid pulses for one cycle with both means and deviations
// (eight fraction bits, floored). the pass runs per channel: product,
// difference, square root, a divide for the deviation, a divide for the
// mean, write. the square root and divide are one bit per cycle
// shift/subtract units.
// sample_count sets the set length over the APB port (0 acts as 1,
// values above MAX_SAMPLES act as MAX_SAMPLES); write it while idle.
// reset empties the accumulators and loads sample_count with 24.
// the receiver cannot stall: each result is valid for exactly one cycle.
module mean_and_std_deviation import mstd_pkg::*; #(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  sample_t           sample,
  output logic              result_valid,
  output result_t           result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam logic [8:0] MaxN = 9'(MAX_SAMPLES);

  logic [SEEN_W-1:0] sample_count;
  logic [SEEN_W-1:0] n_eff;
  mstd_cmd_t         cmd;
  mstd_status_t      status;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= SEEN_W'(CNT_RST);
    end else if (psel && penable && pwrite && paddr == ADDR_SAMPLE_COUNT) begin
      sample_count <= pwdata[SEEN_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_SAMPLE_COUNT) prdata = 32'(sample_count);
  end

  always_comb begin
    if (sample_count == '0) begin
      n_eff = SEEN_W'(1);
    end else if ({3'b000, sample_count} > MaxN) begin
      n_eff = MaxN[SEEN_W-1:0];
    end else begin
      n_eff = sample_count;
    end
  end

  mstd_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .status       (status),
    .cmd          (cmd),
    .busy         (busy),
    .result_valid (result_valid)
  );

  mstd_datapath u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .status (status),
    .sample (sample),
    .n_eff  (n_eff),
    .result (result)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("busy not raised after accept");

  a_valid_pulse: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid) else $error("result strobe longer than one cycle");

  a_valid_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> busy) else $error("result while idle");

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
module testbench;
  import mstd_pkg::*;

  localparam int CYCLE_LIMIT = 1500000;
  localparam int SETTLE      = 200;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  sample_t     sample;
  logic        result_valid;
  result_t     result;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  mean_and_std_deviation i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .sample(sample),
    .result_valid(result_valid), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor state
  logic [5:0]   set_length;
  logic [5:0]   seen_count;
  longint       sum_a, sum_b;
  longint       sumsq_a, sumsq_b;
  result_t      pending_stats[$];
  int           fail_count;
  int           cycle_count;
  bit           quiet;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("mean_and_std_deviation test failed");
      $finish;
    end
  end

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic void channel_stats(longint s, longint q, longint n,
                                        output logic [OUT_W-1:0] mean,
                                        output logic [OUT_W-1:0] dev);
    longint m;
    longint mag;
    logic [63:0] d;
    m = (s * 16) / n;
    if (((s * 16) % n) != 0 && s < 0) m = m - 1;
    mag = (s < 0) ? -s : s;
    d = n * q - mag * mag;
    mean = m[OUT_W-1:0];
    dev = OUT_W'(int_sqrt(d * 256) / n);
  endfunction

  // accumulate one sample pair; queue the statistics when a set closes
  function automatic void accumulate_pair(sample_t smp);
    longint a, b, n;
    result_t r;
    a = smp.sample_a;
    b = smp.sample_b;
    n = set_length;
    if (n == 0) n = 1;
    if (n > MAX_SAMPLES_DEF) n = MAX_SAMPLES_DEF;
    sum_a += a;
    sum_b += b;
    sumsq_a += a * a;
    sumsq_b += b * b;
    seen_count = seen_count + 6'd1;
    if (seen_count >= n) begin
      channel_stats(sum_a, sumsq_a, seen_count, r.mean_a, r.deviation_a);
      channel_stats(sum_b, sumsq_b, seen_count, r.mean_b, r.deviation_b);
      pending_stats.push_back(r);
      seen_count = 0;
      sum_a = 0; sum_b = 0; sumsq_a = 0; sumsq_b = 0;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (pending_stats.size() == 0) begin
        $error("result with nothing expected");
        fail_count++;
      end else begin
        result_t e;
        e = pending_stats.pop_front();
        if (result.mean_a !== e.mean_a) begin
          $error("mean_a expected %0d got %0d", e.mean_a, result.mean_a); fail_count++;
        end
        if (result.mean_b !== e.mean_b) begin
          $error("mean_b expected %0d got %0d", e.mean_b, result.mean_b); fail_count++;
        end
        if (result.deviation_a !== e.deviation_a) begin
          $error("deviation_a expected %0d got %0d", e.deviation_a, result.deviation_a);
          fail_count++;
        end
        if (result.deviation_b !== e.deviation_b) begin
          $error("deviation_b expected %0d got %0d", e.deviation_b, result.deviation_b);
          fail_count++;
        end
      end
    end
  end

  // leaves start high, unless it inserts a random gap, so back-to-back items keep it up
  task automatic send_pair(logic [15:0] a, logic [15:0] b);
    sample_t s;
    s.sample_a = a;
    s.sample_b = b;
    start <= 1'b1;
    sample <= s;
    @(posedge clk);
    while (busy) @(posedge clk);
    accumulate_pair(s);
    if (!quiet && $urandom_range(99) < 15) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_count(logic [31:0] value);
    drain();
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= ADDR_SAMPLE_COUNT; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    set_length = value[5:0];
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_value();
    case ($urandom_range(7))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'(signed'($urandom_range(0, 40)) - 20);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_default_set();
    // reset length of 24 with full-scale samples on channel a
    for (int i = 0; i < 24; i++)
      send_pair((i % 2) ? 16'h7fff : 16'h8000, (i % 3) ? 16'hffff : 16'h0001);
  endtask

  task automatic test_length_extremes();
    write_count(1);
    send_pair(16'h7fff, 16'h8000);
    send_pair(16'h0000, 16'hffff);
    write_count(0);     // acts as one
    send_pair(16'h8000, 16'h7fff);
    write_count(63);    // clamps to the maximum
    for (int i = 0; i < 32; i++) send_pair(16'h8000, pick_value());
    write_count(32'hffff_ffe1);
    for (int i = 0; i < 32; i++) send_pair(16'h7fff, 16'h8000);
  endtask

  task automatic test_shrink_mid_set();
    write_count(8);
    repeat (5) send_pair(pick_value(), pick_value());
    write_count(3);     // next item closes with six samples
    send_pair(16'h1234, 16'hedcb);
  endtask

  task automatic test_random_sets();
    int sent;
    int len;
    logic [31:0] noise;
    sent = 0;
    while (sent < 650) begin
      case ($urandom_range(9))
        0: len = 32;
        1: len = $urandom_range(33, 63);
        2: len = 0;
        default: len = $urandom_range(1, 8);
      endcase
      noise = $urandom;
      write_count({noise[31:6], 6'(len)});
      quiet = ($urandom_range(5) == 0);
      repeat ($urandom_range(1, 3) * ((len == 0) ? 1 : (len > 32 ? 32 : len)) +
              $urandom_range(0, 2)) begin
        send_pair(pick_value(), pick_value());
        sent++;
      end
      quiet = 0;
    end
  endtask

  initial begin
    rst = 1'b1; start = 1'b0; sample = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    set_length = 6'(CNT_RST); seen_count = 0;
    sum_a = 0; sum_b = 0; sumsq_a = 0; sumsq_b = 0;
    fail_count = 0; cycle_count = 0; quiet = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_set();
    test_length_extremes();
    test_shrink_mid_set();
    test_random_sets();
    drain();
    if (fail_count == 0) begin
      $display("mean_and_std_deviation test passed");
    end else begin
      $display("mean_and_std_deviation test failed");
    end
    $finish;
  end

endmodule
